// ----- rtl/ilmq_pkg.sv -----
// Package for the interval list merge/query block.
// Holds the entry type, kind codes, controller states and control structs.
`default_nettype none
package ilmq_pkg;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_MERGE = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    typedef struct packed {
        logic [6:0]  cnt;
        logic [32:0] hi;
        logic [31:0] lo;
    } t_entry;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADD,
        ST_M_START,
        ST_S_RDKEY,
        ST_S_KEY,
        ST_S_CHK,
        ST_S_CMP,
        ST_W_START,
        ST_W_CUR,
        ST_W_RD,
        ST_W_CMP,
        ST_W_END,
        ST_M_DONE,
        ST_Q_START,
        ST_Q_RD,
        ST_Q_CMP,
        ST_Q_END
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ADD,
        OP_SORT_INIT,
        OP_RD_I,
        OP_KEY,
        OP_INS_ZERO,
        OP_RD_J,
        OP_INS_CMP,
        OP_RD_0,
        OP_CUR,
        OP_RD_NX,
        OP_SWEEP,
        OP_SWEEP_END,
        OP_EMIT_MERGE,
        OP_Q_INIT,
        OP_Q_CMP,
        OP_EMIT_QUERY
    } t_op;

    typedef struct packed {
        logic total_zero;
        logic total_lt2;
        logic i_last;
        logic j_zero;
        logic greater;
        logic nx_last;
        logic hit;
        logic pend_v;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

// ----- rtl/ilmq_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module ilmq_ram #(
    parameter int unsigned W = 8,
    parameter int unsigned D = 64,
    localparam int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ----- rtl/ilmq_ctrl.sv -----
// Controller FSM: sequences add, insertion sort, merge sweep and query scan.
// Depends on ilmq_pkg; drives one datapath op per cycle.
`default_nettype none
module ilmq_ctrl import ilmq_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    input  wire logic [1:0] i_kind,
    input  wire t_status    i_st,
    output logic            o_s_tready,
    output t_op             o_op
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    case (i_kind)
                        KIND_ADD:   n_state = ST_ADD;
                        KIND_MERGE: n_state = ST_M_START;
                        KIND_QUERY: n_state = ST_Q_START;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ADD:     if (i_st.out_free) n_state = ST_IDLE;
            ST_M_START: n_state = i_st.total_lt2 ? ST_M_DONE : ST_S_RDKEY;
            ST_S_RDKEY: n_state = ST_S_KEY;
            ST_S_KEY:   n_state = ST_S_CHK;
            ST_S_CHK: begin
                if (!i_st.j_zero) begin
                    n_state = ST_S_CMP;
                end else begin
                    n_state = i_st.i_last ? ST_W_START : ST_S_RDKEY;
                end
            end
            ST_S_CMP: begin
                if (i_st.greater) begin
                    n_state = ST_S_CHK;
                end else begin
                    n_state = i_st.i_last ? ST_W_START : ST_S_RDKEY;
                end
            end
            ST_W_START: n_state = ST_W_CUR;
            ST_W_CUR:   n_state = ST_W_RD;
            ST_W_RD:    n_state = ST_W_CMP;
            ST_W_CMP:   n_state = i_st.nx_last ? ST_W_END : ST_W_RD;
            ST_W_END:   n_state = ST_M_DONE;
            ST_M_DONE:  if (i_st.out_free) n_state = ST_IDLE;
            ST_Q_START: n_state = i_st.total_zero ? ST_Q_END : ST_Q_RD;
            ST_Q_RD:    n_state = ST_Q_CMP;
            ST_Q_CMP: begin
                if (!(i_st.hit && i_st.pend_v && !i_st.out_free)) begin
                    n_state = i_st.i_last ? ST_Q_END : ST_Q_RD;
                end
            end
            ST_Q_END:   if (i_st.out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_op       = OP_NONE;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) o_op = OP_LOAD;
            end
            ST_ADD:     if (i_st.out_free) o_op = OP_ADD;
            ST_M_START: if (!i_st.total_lt2) o_op = OP_SORT_INIT;
            ST_S_RDKEY: o_op = OP_RD_I;
            ST_S_KEY:   o_op = OP_KEY;
            ST_S_CHK:   o_op = i_st.j_zero ? OP_INS_ZERO : OP_RD_J;
            ST_S_CMP:   o_op = OP_INS_CMP;
            ST_W_START: o_op = OP_RD_0;
            ST_W_CUR:   o_op = OP_CUR;
            ST_W_RD:    o_op = OP_RD_NX;
            ST_W_CMP:   o_op = OP_SWEEP;
            ST_W_END:   o_op = OP_SWEEP_END;
            ST_M_DONE:  if (i_st.out_free) o_op = OP_EMIT_MERGE;
            ST_Q_START: o_op = OP_Q_INIT;
            ST_Q_RD:    o_op = OP_RD_I;
            ST_Q_CMP: begin
                if (!(i_st.hit && i_st.pend_v && !i_st.out_free)) o_op = OP_Q_CMP;
            end
            ST_Q_END:   if (i_st.out_free) o_op = OP_EMIT_QUERY;
            default:    o_op = OP_NONE;
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/ilmq_dp.sv -----
// Datapath: entry table RAM, sort/sweep/scan counters, held hit, output word.
// Depends on ilmq_pkg and ilmq_ram.
`default_nettype none
module ilmq_dp import ilmq_pkg::*; #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_op         i_op,
    input  wire logic [31:0] i_position,
    input  wire logic [31:0] i_length,
    input  wire logic [32:0] i_range_lo,
    input  wire logic [32:0] i_range_hi,
    input  wire logic        i_m_tready,
    output t_status          o_st,
    output logic             o_m_tvalid,
    output logic [1:0]       o_done_kind,
    output logic             o_status,
    output logic             o_hit,
    output logic [5:0]       o_entry_index,
    output logic [31:0]      o_entry_lo,
    output logic [32:0]      o_entry_hi,
    output logic [6:0]       o_entry_count,
    output logic [6:0]       o_total_entries,
    output logic             o_last
);
    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned EW = $bits(t_entry);

    logic [31:0] r_pos, r_len;
    logic [32:0] r_rlo, r_rhi;
    logic [CW-1:0] r_total, n_total;
    logic [CW-1:0] r_i, n_i, r_j, n_j, r_t, n_t, r_nx, n_nx;
    t_entry r_key, n_key, r_cur, n_cur, r_pend, n_pend;
    logic [AW-1:0] r_pend_idx, n_pend_idx;
    logic r_pend_v, n_pend_v;

    logic r_ovalid, n_ovalid;
    logic [1:0] r_okind, n_okind;
    logic r_ostat, n_ostat, r_ohit, n_ohit, r_olast, n_olast;
    logic [5:0] r_oidx, n_oidx;
    t_entry r_oent, n_oent;
    logic [6:0] r_ototal, n_ototal;

    logic we, re;
    logic [AW-1:0] waddr, raddr;
    t_entry wdata, rd;
    logic [EW-1:0] rdata_raw;
    logic [CW-1:0] jm1, i_inc, t_inc;
    logic full, out_free, greater, hit, cur_zero;
    t_entry add_ent, fold_ent;

    ilmq_ram #(.W(EW), .D(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata_raw)
    );

    assign rd       = t_entry'(rdata_raw);
    assign jm1      = r_j - CW'(1);
    assign i_inc    = r_i + CW'(1);
    assign t_inc    = r_t + CW'(1);
    assign full     = (r_total >= CW'(CAPACITY));
    assign out_free = !r_ovalid || i_m_tready;
    // stable order: move only when strictly greater
    assign greater  = (rd.lo > r_key.lo) || ((rd.lo == r_key.lo) && (rd.hi > r_key.hi));
    assign hit      = (r_rlo <= rd.hi) && (r_rhi >= {1'b0, rd.lo});
    assign cur_zero = (r_cur.lo == '0) && (r_cur.hi == '0);

    assign add_ent.lo  = r_pos;
    assign add_ent.hi  = {1'b0, r_pos} + {1'b0, r_len};
    assign add_ent.cnt = 7'd1;

    assign fold_ent.lo  = r_cur.lo;
    assign fold_ent.hi  = (r_cur.hi < rd.hi) ? rd.hi : r_cur.hi;
    assign fold_ent.cnt = r_cur.cnt + rd.cnt;

    always_comb begin
        o_st.total_zero = (r_total == '0);
        o_st.total_lt2  = (r_total < CW'(2));
        o_st.i_last     = (i_inc == r_total);
        o_st.j_zero     = (r_j == '0);
        o_st.greater    = greater;
        o_st.nx_last    = ((r_nx + CW'(1)) == r_total);
        o_st.hit        = hit;
        o_st.pend_v     = r_pend_v;
        o_st.out_free   = out_free;
    end

    // RAM ports
    always_comb begin
        we    = 1'b0;
        waddr = r_j[AW-1:0];
        wdata = r_key;
        re    = 1'b0;
        raddr = r_i[AW-1:0];
        case (i_op)
            OP_ADD: begin
                we    = !full;
                waddr = r_total[AW-1:0];
                wdata = add_ent;
            end
            OP_INS_ZERO: we = 1'b1;
            OP_INS_CMP: begin
                we    = 1'b1;
                wdata = greater ? rd : r_key;
            end
            OP_SWEEP: begin
                we    = !cur_zero && (r_cur.hi < {1'b0, rd.lo});
                waddr = r_t[AW-1:0];
                wdata = r_cur;
            end
            OP_SWEEP_END: begin
                we    = 1'b1;
                waddr = r_t[AW-1:0];
                wdata = r_cur;
            end
            OP_RD_I:  re = 1'b1;
            OP_RD_J: begin
                re    = 1'b1;
                raddr = jm1[AW-1:0];
            end
            OP_RD_0: begin
                re    = 1'b1;
                raddr = '0;
            end
            OP_RD_NX: begin
                re    = 1'b1;
                raddr = r_nx[AW-1:0];
            end
            default: ;
        endcase
    end

    // register updates
    always_comb begin
        n_total    = r_total;
        n_i        = r_i;
        n_j        = r_j;
        n_t        = r_t;
        n_nx       = r_nx;
        n_key      = r_key;
        n_cur      = r_cur;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        n_pend_v   = r_pend_v;
        n_ovalid   = r_ovalid && !i_m_tready;
        n_okind    = r_okind;
        n_ostat    = r_ostat;
        n_ohit     = r_ohit;
        n_olast    = r_olast;
        n_oidx     = r_oidx;
        n_oent     = r_oent;
        n_ototal   = r_ototal;
        case (i_op)
            OP_ADD: begin
                if (!full) n_total = r_total + CW'(1);
                n_ovalid = 1'b1;
                n_okind  = KIND_ADD;
                n_ostat  = full;
                n_ohit   = 1'b0;
                n_olast  = 1'b1;
                n_oidx   = '0;
                n_oent   = '0;
                n_ototal = full ? 7'(r_total) : 7'(r_total + CW'(1));
            end
            OP_SORT_INIT: n_i = CW'(1);
            OP_KEY: begin
                n_key = rd;
                n_j   = r_i;
            end
            OP_INS_ZERO: n_i = i_inc;
            OP_INS_CMP: begin
                if (greater) n_j = jm1;
                else         n_i = i_inc;
            end
            OP_CUR: begin
                n_cur = rd;
                n_t   = '0;
                n_nx  = CW'(1);
            end
            OP_SWEEP: begin
                if (cur_zero) begin
                    n_cur = rd;
                end else if (r_cur.hi >= {1'b0, rd.lo}) begin
                    n_cur = fold_ent;
                end else begin
                    n_t   = t_inc;
                    n_cur = rd;
                end
                n_nx = r_nx + CW'(1);
            end
            OP_SWEEP_END: if (t_inc < r_total) n_total = t_inc;
            OP_EMIT_MERGE: begin
                n_ovalid = 1'b1;
                n_okind  = KIND_MERGE;
                n_ostat  = 1'b0;
                n_ohit   = 1'b0;
                n_olast  = 1'b1;
                n_oidx   = '0;
                n_oent   = '0;
                n_ototal = 7'(r_total);
            end
            OP_Q_INIT: begin
                n_i      = '0;
                n_pend_v = 1'b0;
            end
            OP_Q_CMP: begin
                if (hit) begin
                    // a later hit exists, so the held one is not last
                    if (r_pend_v) begin
                        n_ovalid = 1'b1;
                        n_okind  = KIND_QUERY;
                        n_ostat  = 1'b0;
                        n_ohit   = 1'b1;
                        n_olast  = 1'b0;
                        n_oidx   = 6'(r_pend_idx);
                        n_oent   = r_pend;
                        n_ototal = 7'(r_total);
                    end
                    n_pend     = rd;
                    n_pend_idx = r_i[AW-1:0];
                    n_pend_v   = 1'b1;
                end
                n_i = i_inc;
            end
            OP_EMIT_QUERY: begin
                n_ovalid = 1'b1;
                n_okind  = KIND_QUERY;
                n_ostat  = 1'b0;
                n_ohit   = r_pend_v;
                n_olast  = 1'b1;
                n_oidx   = r_pend_v ? 6'(r_pend_idx) : '0;
                n_oent   = r_pend_v ? r_pend : '0;
                n_ototal = 7'(r_total);
                n_pend_v = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= '0;
            r_ovalid <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_total  <= n_total;
            r_ovalid <= n_ovalid;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_LOAD) begin
            r_pos <= i_position;
            r_len <= i_length;
            r_rlo <= i_range_lo;
            r_rhi <= i_range_hi;
        end
        r_i        <= n_i;
        r_j        <= n_j;
        r_t        <= n_t;
        r_nx       <= n_nx;
        r_key      <= n_key;
        r_cur      <= n_cur;
        r_pend     <= n_pend;
        r_pend_idx <= n_pend_idx;
        r_okind    <= n_okind;
        r_ostat    <= n_ostat;
        r_ohit     <= n_ohit;
        r_olast    <= n_olast;
        r_oidx     <= n_oidx;
        r_oent     <= n_oent;
        r_ototal   <= n_ototal;
    end

    assign o_m_tvalid      = r_ovalid;
    assign o_done_kind     = r_okind;
    assign o_status        = r_ostat;
    assign o_hit           = r_ohit;
    assign o_entry_index   = r_oidx;
    assign o_entry_lo      = r_oent.lo;
    assign o_entry_hi      = r_oent.hi;
    assign o_entry_count   = r_oent.cnt;
    assign o_total_entries = r_ototal;
    assign o_last          = r_olast;

`ifndef ASSERT_OFF
    a_total_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(CAPACITY))
        else $error("entry total above capacity");
    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_ADD && !full) |=> (r_total == $past(r_total) + CW'(1)))
        else $error("add did not grow table");
    a_sweep_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_SWEEP) |-> (r_t < r_nx && r_nx < r_total))
        else $error("sweep pointers out of order");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_EMIT_QUERY || i_op == OP_EMIT_MERGE || i_op == OP_ADD) |-> out_free)
        else $error("result word overwritten");
`endif
endmodule
`default_nettype wire

// ----- rtl/interval_list_merge_query_top.sv -----
// Top level of the interval list merge/query block.
// Depends on ilmq_pkg, ilmq_ctrl, ilmq_dp (which holds ilmq_ram).
//
//  channel  | dir | tdata                                | tuser       | tlast
//  ---------+-----+--------------------------------------+-------------+------
//  s (in)   | in  | position,length,range_lo,range_hi    | kind        | -
//  m (out)  | out | status,hit,index,lo,hi,count,total   | done_kind   | last
//
// A query scans the stored entries and a merge runs an insertion sort and
// then a sweep over them, reading one entry at a time through the single
// read port of the table RAM.
// Synchronous active-low reset empties the table; entry contents are not cleared.
// Input is taken only between items; the output word register lets an item
// finish while its last word waits, and a query stalls on a full output.
`default_nettype none
module interval_list_merge_query_top import ilmq_pkg::*; #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // [31:0] position, [63:32] length, [96:64] range_lo, [129:97] range_hi
    input  wire logic [135:0] i_s_tdata,
    // [1:0] kind
    input  wire logic [1:0]   i_s_tuser,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // [0] status, [1] hit, [7:2] entry_index, [39:8] entry_lo, [72:40] entry_hi,
    // [79:73] entry_count, [86:80] total_entries
    output logic [87:0]       o_m_tdata,
    // [1:0] done_kind
    output logic [1:0]        o_m_tuser,
    output logic              o_m_tlast
);
    t_op     op;
    t_status st;
    logic       status, hit;
    logic [5:0] idx;
    logic [31:0] elo;
    logic [32:0] ehi;
    logic [6:0] ecnt, etot;

    ilmq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_kind     (i_s_tuser),
        .i_st       (st),
        .o_s_tready (o_s_tready),
        .o_op       (op)
    );

    ilmq_dp #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (op),
        .i_position      (i_s_tdata[31:0]),
        .i_length        (i_s_tdata[63:32]),
        .i_range_lo      (i_s_tdata[96:64]),
        .i_range_hi      (i_s_tdata[129:97]),
        .i_m_tready      (i_m_tready),
        .o_st            (st),
        .o_m_tvalid      (o_m_tvalid),
        .o_done_kind     (o_m_tuser),
        .o_status        (status),
        .o_hit           (hit),
        .o_entry_index   (idx),
        .o_entry_lo      (elo),
        .o_entry_hi      (ehi),
        .o_entry_count   (ecnt),
        .o_total_entries (etot),
        .o_last          (o_m_tlast)
    );

    assign o_m_tdata = {1'b0, etot, ecnt, ehi, elo, idx, hit, status};
endmodule
`default_nettype wire

// ----- bench/interval_list_merge_query_checker.sv -----
// Checker for interval_list_merge_query_top: watches both stream channels,
// predicts result words from a local copy of the interval table and compares.
// Depends on ilmq_pkg for the kind codes.
module interval_list_merge_query_checker import ilmq_pkg::*; #(
    parameter int CAP = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    input  wire logic         i_s_tready,
    input  wire logic [135:0] i_s_tdata,
    input  wire logic [1:0]   i_s_tuser,
    input  wire logic         i_m_tvalid,
    input  wire logic         i_m_tready,
    input  wire logic [87:0]  i_m_tdata,
    input  wire logic [1:0]   i_m_tuser,
    input  wire logic         i_m_tlast,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  kind;
        logic        last;
        logic [87:0] data;
    } t_word;

    logic [31:0] tbl_lo [CAP];
    logic [32:0] tbl_hi [CAP];
    logic [6:0]  tbl_cnt [CAP];
    int          tbl_n;
    t_word       expected_words [$];

    assign o_pending = expected_words.size();

    function automatic t_word make_word(logic [1:0] kind, logic st, logic hit, int idx,
                                        logic [31:0] lo, logic [32:0] hi,
                                        logic [6:0] cnt, logic last);
        t_word w;
        w.kind = kind;
        w.last = last;
        w.data = {1'b0, 7'(tbl_n), cnt, hi, lo, 6'(idx), hit, st};
        return w;
    endfunction

    task automatic sort_and_fold();
        int t, nx, j;
        logic [31:0] lo;
        logic [32:0] hi;
        logic [6:0] c;
        t = 0;
        if (tbl_n < 2) return;
        for (int i = 1; i < tbl_n; i++) begin
            lo = tbl_lo[i]; hi = tbl_hi[i]; c = tbl_cnt[i]; j = i;
            while (j > 0 && (tbl_lo[j-1] > lo || (tbl_lo[j-1] == lo && tbl_hi[j-1] > hi))) begin
                tbl_lo[j] = tbl_lo[j-1]; tbl_hi[j] = tbl_hi[j-1]; tbl_cnt[j] = tbl_cnt[j-1];
                j--;
            end
            tbl_lo[j] = lo; tbl_hi[j] = hi; tbl_cnt[j] = c;
        end
        for (nx = 1; nx < tbl_n; nx++) begin
            if (tbl_lo[t] == 0 && tbl_hi[t] == 0) begin
                // empty front entry takes the next one, its own count lost
                tbl_lo[t] = tbl_lo[nx]; tbl_hi[t] = tbl_hi[nx]; tbl_cnt[t] = tbl_cnt[nx];
            end else if (tbl_hi[t] >= {1'b0, tbl_lo[nx]}) begin
                if (tbl_hi[t] < tbl_hi[nx]) tbl_hi[t] = tbl_hi[nx];
                tbl_cnt[t] = tbl_cnt[t] + tbl_cnt[nx];
                tbl_lo[nx] = 0; tbl_hi[nx] = 0; tbl_cnt[nx] = 0;
            end else begin
                t++;
                if (t != nx) begin
                    tbl_lo[t] = tbl_lo[nx]; tbl_hi[t] = tbl_hi[nx]; tbl_cnt[t] = tbl_cnt[nx];
                end
            end
        end
        if (t + 1 < tbl_n) tbl_n = t + 1;
    endtask

    task automatic predict_item(logic [1:0] kind, logic [135:0] d);
        logic [32:0] rlo, rhi;
        int hits;
        hits = 0;
        rlo = d[96:64];
        rhi = d[129:97];
        case (kind)
            KIND_ADD: begin
                if (tbl_n >= CAP) begin
                    expected_words.push_back(make_word(KIND_ADD, 1'b1, 0, 0, 0, 0, 0, 1'b1));
                end else begin
                    tbl_lo[tbl_n] = d[31:0];
                    tbl_hi[tbl_n] = {1'b0, d[31:0]} + {1'b0, d[63:32]};
                    tbl_cnt[tbl_n] = 7'd1;
                    tbl_n++;
                    expected_words.push_back(make_word(KIND_ADD, 1'b0, 0, 0, 0, 0, 0, 1'b1));
                end
            end
            KIND_MERGE: begin
                sort_and_fold();
                expected_words.push_back(make_word(KIND_MERGE, 1'b0, 0, 0, 0, 0, 0, 1'b1));
            end
            KIND_QUERY: begin
                for (int i = 0; i < tbl_n; i++) begin
                    if (rlo <= tbl_hi[i] && rhi >= {1'b0, tbl_lo[i]}) begin
                        expected_words.push_back(make_word(KIND_QUERY, 1'b0, 1'b1, i,
                            tbl_lo[i], tbl_hi[i], tbl_cnt[i], 1'b0));
                        hits++;
                    end
                end
                if (hits == 0)
                    expected_words.push_back(make_word(KIND_QUERY, 1'b0, 0, 0, 0, 0, 0, 1'b1));
                else
                    expected_words[$].last = 1'b1;
            end
            default: ; // unknown kind: no result
        endcase
    endtask

    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            tbl_n <= 0;
            o_fail_count <= 0;
            expected_words.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word kind=%0d data=%h last=%b",
                             $time, i_m_tuser, i_m_tdata, i_m_tlast);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    w = expected_words.pop_front();
                    if (w.kind !== i_m_tuser || w.last !== i_m_tlast || w.data !== i_m_tdata) begin
                        $display("%0t: mismatch expected kind=%0d last=%b data=%h", $time,
                                 w.kind, w.last, w.data);
                        $display("%0t:          actual   kind=%0d last=%b data=%h", $time,
                                 i_m_tuser, i_m_tlast, i_m_tdata);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) predict_item(i_s_tuser, i_s_tdata);
        end
    end
endmodule

// ----- bench/interval_list_merge_query_top_tb.sv -----
// Testbench top for interval_list_merge_query_top: drives add, merge and
// query words with random gaps and stalls; depends on the checker and ilmq_pkg.
module interval_list_merge_query_top_tb import ilmq_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 64;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [135:0] s_data = '0;
    logic [1:0]   s_user = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [87:0]  m_data;
    logic [1:0]   m_user;
    logic         m_last;
    int           fail_count;
    int           pending;

    // idle percentages, changed per phase
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_off = 0;      // receiver forced-stall cycles left
    logic         stim_done = 1'b0;

    always #5 i_clk = ~i_clk;

    interval_list_merge_query_top #(.CAPACITY(CAP)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .o_s_tready(s_ready), .i_s_tdata(s_data), .i_s_tuser(s_user),
        .o_m_tvalid(m_valid), .i_m_tready(m_ready), .o_m_tdata(m_data),
        .o_m_tuser(m_user), .o_m_tlast(m_last)
    );

    interval_list_merge_query_checker #(.CAP(CAP)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .i_s_tready(s_ready), .i_s_tdata(s_data), .i_s_tuser(s_user),
        .i_m_tvalid(m_valid), .i_m_tready(m_ready), .i_m_tdata(m_data),
        .i_m_tuser(m_user), .i_m_tlast(m_last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver: random stalls, plus a long forced hold-off when requested
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= stim_done || ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // one word on the input channel; optional random idle cycles first
    task automatic send_word(logic [1:0] kind, logic [31:0] pos, logic [31:0] len,
                             logic [32:0] rlo, logic [32:0] rhi);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= kind;
        s_data  <= {6'd0, rhi, rlo, len, pos};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
    endtask

    task automatic go_idle();
        s_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        go_idle();
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word32(int mode);
        case (mode)
            0: return 32'($urandom_range(300));
            1: return 32'hFFFF_FFFF - 32'($urandom_range(50));
            default: return $urandom;
        endcase
    endfunction

    task automatic random_item();
        int r;
        logic [32:0] a, b;
        r = $urandom_range(99);
        a = {1'($urandom), $urandom};
        b = {1'($urandom), $urandom};
        if (r < 55)
            send_word(KIND_ADD, rand_word32($urandom_range(2)),
                      ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(80)), a, b);
        else if (r < 68)
            send_word(KIND_MERGE, $urandom, $urandom, a, b);
        else if (r < 96) begin
            if ($urandom_range(3) != 0) begin
                a = 33'($urandom_range(350));
                b = a + 33'($urandom_range(100));
            end
            send_word(KIND_QUERY, $urandom, $urandom, a, b);
        end else
            send_word(2'd3, $urandom, $urandom, a, b);   // ignored kind
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty merge/query, field extremes, zero entry, reversed range
        send_word(KIND_MERGE, 0, 0, 0, 0);
        send_word(KIND_QUERY, 0, 0, 0, 33'h1_FFFF_FFFF);
        send_word(KIND_ADD, 0, 0, 0, 0);
        send_word(KIND_MERGE, 0, 0, 0, 0);
        send_word(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
        send_word(KIND_ADD, 0, 0, 0, 0);
        send_word(KIND_ADD, 10, 5, 0, 0);
        send_word(KIND_ADD, 12, 20, 0, 0);
        send_word(KIND_ADD, 10, 5, 0, 0);
        send_word(KIND_ADD, 40, 0, 0, 0);
        send_word(KIND_QUERY, 0, 0, 33'h1_FFFF_FFFF, 33'h1_FFFF_FFFF);
        send_word(KIND_QUERY, 0, 0, 33'd100, 33'd5);
        send_word(KIND_MERGE, 0, 0, 0, 0);
        send_word(KIND_QUERY, 0, 0, 0, 33'h1_FFFF_FFFF);
        send_word(KIND_QUERY, 0, 0, 33'd33, 33'd39);
        send_word(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF, 33'h1_FFFF_FFFF);
        // fill to capacity, then overflow
        while (u_checker.tbl_n < CAP)
            send_word(KIND_ADD, rand_word32(0), 32'($urandom_range(10)), 0, 0);
        send_word(KIND_ADD, 5, 5, 0, 0);
        send_word(KIND_QUERY, 0, 0, 0, 33'h1_FFFF_FFFF);
        send_word(KIND_MERGE, 0, 0, 0, 0);
        // sender waits out every result
        drain();

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 50 : (ph == 3) ? 17 : 0;
            recv_stall_pct = (ph == 2) ? 50 : (ph == 3) ? 17 : 0;
            if (ph == 2) hold_off = 400;   // long receiver hold-off, sender keeps offering
            for (int k = 0; k < 30; k++) begin
                // keep table from saturating forever: near capacity, sometimes send a merge
                if (u_checker.tbl_n >= CAP - 2 && $urandom_range(1))
                    send_word(KIND_MERGE, 0, 0, 0, 0);
                else
                    random_item();
            end
            drain();
        end

        stim_done = 1'b1;
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("interval_list_merge_query_top regression: pass");
        else
            $display("interval_list_merge_query_top regression: fail");
        $finish;
    end

    initial begin
        #100ms;
        $display("interval_list_merge_query_top regression: fail");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/ilmq_pkg.sv
rtl/ilmq_ram.sv
rtl/ilmq_ctrl.sv
rtl/ilmq_dp.sv
rtl/interval_list_merge_query_top.sv
bench/interval_list_merge_query_checker.sv
bench/interval_list_merge_query_top_tb.sv
